// ===== sv/crc32mv_pkg.sv =====
// Shared types, command codes and CRC helpers for the multi-variant CRC-32 engine.
// No dependencies; used by every module of the block.
package crc32mv_pkg;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_FOLD = 2'd1;
    localparam logic [1:0] CMD_FIN  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] VAR_CRC32C = 3'd0;
    localparam logic [2:0] VAR_CRC32  = 3'd1;
    localparam logic [2:0] VAR_MPEG2  = 3'd2;
    localparam logic [2:0] VAR_POSIX  = 3'd3;
    localparam logic [2:0] VAR_ETSI   = 3'd4;

    localparam logic [31:0] POLY_CASTAGNOLI_REFL = 32'h82F6_3B78;
    localparam logic [31:0] POLY_IEEE_REFL       = 32'hEDB8_8320;
    localparam logic [31:0] POLY_IEEE_MSB        = 32'h04C1_1DB7;
    localparam logic [31:0] ALL_ONES             = 32'hFFFF_FFFF;
    localparam logic [31:0] ALL_ZEROS            = 32'h0000_0000;

    localparam logic [3:0] DIGEST_LEN = 4'd4;

    // Queue entry: command already classified by the front end
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       len_ok;
    } t_req;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    // Codes above ETSI fall back to CRC32
    function automatic logic [2:0] sel_variant(input logic [2:0] v);
        sel_variant = (v > VAR_ETSI) ? VAR_CRC32 : v;
    endfunction

    function automatic logic [31:0] init_value(input logic [2:0] v);
        init_value = (v == VAR_POSIX) ? ALL_ZEROS : ALL_ONES;
    endfunction

    function automatic logic [31:0] final_mask(input logic [2:0] v);
        final_mask = (v == VAR_MPEG2) ? ALL_ZEROS : ALL_ONES;
    endfunction

    // One byte through the shift register, eight bit steps unrolled
    function automatic logic [31:0] fold_byte(input logic [2:0] v,
                                              input logic [31:0] crc_in,
                                              input logic [7:0] byte_in);
        logic [31:0] c;
        logic [31:0] poly;
        c    = crc_in;
        poly = (v == VAR_CRC32C) ? POLY_CASTAGNOLI_REFL : POLY_IEEE_REFL;
        if (v <= VAR_CRC32) begin
            c = c ^ {24'd0, byte_in};
            for (int k = 0; k < 8; k++) begin
                c = {1'b0, c[31:1]} ^ (c[0] ? poly : ALL_ZEROS);
            end
        end else begin
            c = c ^ {byte_in, 24'd0};
            for (int k = 0; k < 8; k++) begin
                c = {c[30:0], 1'b0} ^ (c[31] ? POLY_IEEE_MSB : ALL_ZEROS);
            end
        end
        fold_byte = c;
    endfunction

endpackage

// ===== sv/crc32mv_front.sv =====
// Front end: takes input transfers, classifies the command and checks the digest length.
// Depends on crc32mv_pkg; feeds crc32mv_queue.
module crc32mv_front (
    input  logic                [1:0]  i_cmd,
    input  logic                [7:0]  i_data_byte,
    input  logic                [3:0]  i_out_len,
    input  logic                       i_valid,
    input  crc32mv_pkg::t_q_stat       i_q_stat,
    output logic                       o_ready,
    output logic                       o_push,
    output crc32mv_pkg::t_req          o_req
);

    always_comb begin
        o_ready         = !i_q_stat.full;
        // unused command code is taken and dropped here
        o_push          = i_valid && o_ready && (i_cmd != crc32mv_pkg::CMD_NOP);
        o_req.kind      = i_cmd;
        o_req.data_byte = i_data_byte;
        o_req.len_ok    = (i_out_len == crc32mv_pkg::DIGEST_LEN);
    end

endmodule

// ===== sv/crc32mv_queue.sv =====
// Two-entry request queue between front and back end.
// Depends on crc32mv_pkg.
module crc32mv_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  crc32mv_pkg::t_req     i_req,
    input  logic                  i_pop,
    output crc32mv_pkg::t_q_stat  o_stat,
    output crc32mv_pkg::t_req     o_req
);

    crc32mv_pkg::t_req r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;

    always_comb begin
        n_count = r_count + {1'b0, i_push} - {1'b0, i_pop};
        o_stat.valid = (r_count != 2'd0);
        o_stat.full  = (r_count == 2'd2);
        o_req        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// ===== sv/crc32mv_back.sv =====
// Back end: running CRC register, byte fold, finalize and output register.
// Depends on crc32mv_pkg; pops crc32mv_queue.
module crc32mv_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [2:0]            i_variant,
    input  crc32mv_pkg::t_q_stat  i_q_stat,
    input  crc32mv_pkg::t_req     i_req,
    output logic                  o_pop,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_digest,
    output logic                  o_status
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic        r_out_valid;
    logic [31:0] r_digest;
    logic        r_status;
    logic [2:0]  v;
    logic        space;
    logic        fin;

    always_comb begin
        v     = crc32mv_pkg::sel_variant(i_variant);
        space = !r_out_valid || i_out_ready;
        fin   = (i_req.kind == crc32mv_pkg::CMD_FIN);
        // a finalize waits for room in the output register, others never stall
        o_pop = i_q_stat.valid && (!fin || space);
        case (i_req.kind)
            crc32mv_pkg::CMD_INIT: n_crc = crc32mv_pkg::init_value(v);
            crc32mv_pkg::CMD_FOLD: n_crc = crc32mv_pkg::fold_byte(v, r_crc, i_req.data_byte);
            default:               n_crc = r_crc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= crc32mv_pkg::ALL_ONES;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_crc <= n_crc;
            end
            if (o_pop && fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && fin) begin
            r_digest <= i_req.len_ok ? (r_crc ^ crc32mv_pkg::final_mask(v))
                                     : crc32mv_pkg::ALL_ZEROS;
            r_status <= !i_req.len_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digest    = r_digest;
    assign o_status    = r_status;

endmodule

// ===== sv/crc32_multi_variant_engine_top.sv =====
// Multi-variant CRC-32 engine, top level: variant register, front end, queue, back end.
// Depends on crc32mv_pkg, crc32mv_front, crc32mv_queue and crc32mv_back.
//
// Usage:
//   s_axis carries commands: tuser = cmd (init, fold byte, finalize), tdata holds
//   data_byte and the requested digest length. m_axis returns one transfer per
//   finalize: tdata = digest, tuser = status (1 = digest length other than 4).
//   i_cfg_wr_en / i_cfg_wr_data write the variant (0 CRC32C, 1 CRC32, 2 MPEG-2,
//   3 POSIX, 4 ETSI, higher codes act as CRC32); write it only while idle.
//   Throughput: one command per cycle while the queue is not full; each fold is
//   one unrolled 8-bit update of the running CRC register in the back end.
//   A finalize accepted on s_axis passes the queue and then the output register.
//   Reset (synchronous, active low) empties the queue and output register, sets
//   the variant to CRC32 and the running CRC to all ones.
//   When m_axis stalls, a held digest blocks the next finalize and every command
//   behind it in the two-entry queue; s_axis_tready drops once the queue is full.
module crc32_multi_variant_engine_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [7:0] data_byte, [11:8] out_len, [15:12] zero
    input  logic [1:0]   s_axis_tuser,   // [1:0] cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // [31:0] digest
    output logic [0:0]   m_axis_tuser,   // [0] status
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_wr_data
);

    logic [2:0]           r_variant;
    crc32mv_pkg::t_q_stat q_stat;
    crc32mv_pkg::t_req    push_req;
    crc32mv_pkg::t_req    head_req;
    logic                 push;
    logic                 pop;
    logic                 status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= crc32mv_pkg::VAR_CRC32;
        end else if (i_cfg_wr_en) begin
            r_variant <= i_cfg_wr_data;
        end
    end

    crc32mv_front u_front (
        .i_cmd       (s_axis_tuser),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_out_len   (s_axis_tdata[11:8]),
        .i_valid     (s_axis_tvalid),
        .i_q_stat    (q_stat),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_req       (push_req)
    );

    crc32mv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_req   (head_req)
    );

    crc32mv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_variant   (r_variant),
        .i_q_stat    (q_stat),
        .i_req       (head_req),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_digest    (m_axis_tdata),
        .o_status    (status)
    );

    assign m_axis_tuser = status;

endmodule

// ===== tb/sv/crc32mv_digest_checker.sv =====
// Digest checker for the multi-variant CRC-32 engine: tracks the variant and running CRC,
// predicts every finalize transfer and compares it with m_axis. Depends on crc32mv_pkg.
module crc32mv_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [7:0] data_byte, [11:8] out_len, [15:12] zero
    input  logic [1:0]  s_axis_tuser,    // [1:0] cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,    // [31:0] digest
    input  logic [0:0]  m_axis_tuser,    // [0] status
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;
    localparam int   REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [31:0] digest;
        logic        status;
    } t_digest_rec;

    t_digest_rec digest_expected_q[$];
    t_digest_rec want;
    logic [2:0]  variant_reg;
    logic [2:0]  eff_variant;
    logic [31:0] crc_state;

    // Bit-serial update, one message bit per step
    function automatic logic [31:0] crc_shift_byte(input logic [2:0] v,
                                                   input logic [31:0] crc_in,
                                                   input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        if (v == crc32mv_pkg::VAR_CRC32C || v == crc32mv_pkg::VAR_CRC32) begin
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ ((v == crc32mv_pkg::VAR_CRC32C) ?
                             crc32mv_pkg::POLY_CASTAGNOLI_REFL : crc32mv_pkg::POLY_IEEE_REFL);
            end
        end else begin
            for (int i = 7; i >= 0; i--) begin
                fb = c[31] ^ b[i];
                c  = c << 1;
                if (fb)
                    c = c ^ crc32mv_pkg::POLY_IEEE_MSB;
            end
        end
        return c;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        variant_reg  = crc32mv_pkg::VAR_CRC32;
        crc_state    = crc32mv_pkg::ALL_ONES;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            variant_reg = crc32mv_pkg::VAR_CRC32;
            crc_state   = crc32mv_pkg::ALL_ONES;
            digest_expected_q.delete();
        end else begin
            // output side first: a finalize accepted at this edge cannot leave at it
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected digest transfer: digest %08h status %0d",
                                 $realtime, m_axis_tdata, m_axis_tuser[0]);
                end else begin
                    want = digest_expected_q.pop_front();
                    if (m_axis_tdata !== want.digest || m_axis_tuser[0] !== want.status) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected %08h/%0d, got %08h/%0d",
                                     $realtime, want.digest, want.status,
                                     m_axis_tdata, m_axis_tuser[0]);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                eff_variant = (variant_reg > crc32mv_pkg::VAR_ETSI) ? crc32mv_pkg::VAR_CRC32
                                                                    : variant_reg;
                case (s_axis_tuser)
                    crc32mv_pkg::CMD_INIT: begin
                        crc_state = (eff_variant == crc32mv_pkg::VAR_POSIX) ?
                                    crc32mv_pkg::ALL_ZEROS : crc32mv_pkg::ALL_ONES;
                    end
                    crc32mv_pkg::CMD_FOLD: begin
                        crc_state = crc_shift_byte(eff_variant, crc_state, s_axis_tdata[7:0]);
                    end
                    crc32mv_pkg::CMD_FIN: begin
                        if (s_axis_tdata[11:8] != crc32mv_pkg::DIGEST_LEN) begin
                            want.digest = crc32mv_pkg::ALL_ZEROS;
                            want.status = STATUS_BAD_LEN;
                        end else begin
                            want.digest = crc_state ^
                                          ((eff_variant == crc32mv_pkg::VAR_MPEG2) ?
                                           crc32mv_pkg::ALL_ZEROS : crc32mv_pkg::ALL_ONES);
                            want.status = STATUS_OK;
                        end
                        digest_expected_q.push_back(want);
                    end
                    default: ;  // unused code, state untouched
                endcase
            end

            if (i_cfg_wr_en)
                variant_reg = i_cfg_wr_data;
        end
        o_pending = digest_expected_q.size();
    end

endmodule

// ===== tb/sv/tb_crc32_multi_variant_engine_top.sv =====
// Testbench top for crc32_multi_variant_engine_top: clock, reset, command stimulus,
// receiver back-pressure and verdict. Depends on crc32mv_pkg, crc32mv_digest_checker and the DUT.
module tb_crc32_multi_variant_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT     = 200_000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         PHASE_ITEMS     = 140;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [2:0] VAR_UNUSED_LO   = 3'd5;
    localparam logic [2:0] VAR_UNUSED_MID  = 3'd6;
    localparam logic [2:0] VAR_UNUSED_HI   = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_wr_data;

    int fail_count;
    int pending_digests;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int items_sent;

    logic [2:0] phase_variant [9] = '{crc32mv_pkg::VAR_CRC32C, crc32mv_pkg::VAR_ETSI,
                                      crc32mv_pkg::VAR_MPEG2, VAR_UNUSED_HI,
                                      crc32mv_pkg::VAR_POSIX, crc32mv_pkg::VAR_CRC32,
                                      VAR_UNUSED_LO, VAR_UNUSED_MID,
                                      crc32mv_pkg::VAR_CRC32C};

    crc32_multi_variant_engine_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    crc32mv_digest_checker u_digest_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_digests)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("crc32_multi_variant_engine_top regression: fail");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] b, input logic [3:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {4'h0, 12'($urandom_range(0, 4095))};
            s_axis_tuser  <= 2'($urandom_range(0, 3));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, len, b};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd != crc32mv_pkg::CMD_NOP)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_digests != 0);
    endtask

    task automatic write_variant(input logic [2:0] v);
        wait_drained();
        // trailing folds may still sit in the queue
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_message(input bit tidy);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (tidy) begin
            send_cmd(crc32mv_pkg::CMD_INIT, 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)));
            repeat (n)
                send_cmd(crc32mv_pkg::CMD_FOLD, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)));
            send_cmd(crc32mv_pkg::CMD_FIN, 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 9) != 0) ? crc32mv_pkg::DIGEST_LEN
                                                 : 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 4) == 0)
                send_cmd(crc32mv_pkg::CMD_FIN, 8'($urandom_range(0, 255)),
                         crc32mv_pkg::DIGEST_LEN);
        end else begin
            repeat ($urandom_range(1, 6))
                send_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        int phase_start;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = crc32mv_pkg::CMD_INIT;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = crc32mv_pkg::VAR_CRC32;
        i_rst_n       = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 74;
        hold_cycles   = 0;
        items_sent    = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset state, field extremes, bad lengths, repeat and unused command
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        send_cmd(crc32mv_pkg::CMD_INIT, 8'hA5, 4'hF);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h00, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'hFF, 4'hF);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h80, 4'h4);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h01, 4'h4);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'hFF, crc32mv_pkg::DIGEST_LEN);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, 4'hF);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, 4'h3);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, 4'h5);
        send_cmd(crc32mv_pkg::CMD_NOP, 8'hFF, 4'hF);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        write_variant(crc32mv_pkg::VAR_CRC32C);
        send_cmd(crc32mv_pkg::CMD_INIT, 8'h00, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h31, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h32, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'h33, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        // unused code, running value carried over without init
        write_variant(VAR_UNUSED_HI);
        send_cmd(crc32mv_pkg::CMD_FOLD, 8'hC3, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        write_variant(crc32mv_pkg::VAR_POSIX);
        send_cmd(crc32mv_pkg::CMD_INIT, 8'h00, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);
        write_variant(crc32mv_pkg::VAR_MPEG2);
        send_cmd(crc32mv_pkg::CMD_INIT, 8'h00, 4'h0);
        send_cmd(crc32mv_pkg::CMD_FIN, 8'h00, crc32mv_pkg::DIGEST_LEN);

        for (int phase = 0; phase < 9; phase++) begin
            case (phase / 3)
                0: begin send_idle_pct = 7;  recv_idle_pct = 74; end
                1: begin send_idle_pct = 74; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_variant(phase_variant[phase]);
            if (phase == 1) begin
                // long receiver stall while finalizes keep coming: queue fills
                hold_cycles = HOLD_OFF_CYCLES;
                repeat (30)
                    send_cmd(($urandom_range(0, 1) != 0) ? crc32mv_pkg::CMD_FIN
                                                         : crc32mv_pkg::CMD_FOLD,
                             8'($urandom_range(0, 255)), crc32mv_pkg::DIGEST_LEN);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_message($urandom_range(0, 9) != 0);
                if (phase == 4 && items_sent - phase_start >= PHASE_ITEMS / 2
                    && items_sent - phase_start < PHASE_ITEMS / 2 + 8)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending_digests == 0)
            $display("crc32_multi_variant_engine_top regression: pass");
        else
            $display("crc32_multi_variant_engine_top regression: fail");
        $finish;
    end

endmodule
